[rtl/core/elias_fano_block_encoder_core_macros.svh]
// Assertion macros shared by the block encoder core modules.
`ifndef ELIAS_FANO_BLOCK_ENCODER_CORE_MACROS_SVH
`define ELIAS_FANO_BLOCK_ENCODER_CORE_MACROS_SVH

// Checks the consequent in the same cycle as the antecedent.
`define EFBE_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Checks the consequent in the cycle after the antecedent.
`define EFBE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/efbe_pkg.sv]
// Types, constants and helpers shared by the block encoder core.
package efbe_pkg;

  localparam int SUM_BITS         = 40;
  localparam int VALUE_W          = 32;
  localparam int CHUNK_W          = 64;
  localparam int CHUNK_BITS_W     = 7;
  localparam int WIDTH_FIELD_BITS = 7;
  localparam int HINT_FIELD_BITS  = 10;
  localparam int HINT_SLOTS       = 6;
  localparam int FILL_BITS        = 6;
  localparam int WIDTH_BITS       = 6;
  localparam int MAX_WIDTH        = 40;
  localparam int THR_BITS         = SUM_BITS + FILL_BITS + 1;

  localparam logic KIND_ADD   = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_HINT,
    BK_LOW,
    BK_HIGH
  } back_state_t;

  typedef struct packed {
    logic                                 bank;
    logic [FILL_BITS-1:0]                 fill;
    logic [SUM_BITS-1:0]                  last;
    logic [WIDTH_BITS-1:0]                width;
    logic [HINT_SLOTS-1:0][SUM_BITS-1:0]  hint_sum;
  } job_t;

  // Element index that a hint refers to, clamped to the last element.
  function automatic int hint_index(input int mult, input int step, input int bsize);
    int idx;
    idx = mult * step - 1;
    if (idx > bsize - 1) begin
      idx = bsize - 1;
    end
    return idx;
  endfunction

endpackage

[rtl/core/efbe_in_if.sv]
// Input item channel: add or flush command with its value.
interface efbe_in_if;
  import efbe_pkg::*;

  logic               valid;
  logic               ready;
  logic               kind;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output kind, output value, input ready);
  modport sink (input valid, input kind, input value, output ready);
endinterface

[rtl/core/efbe_out_if.sv]
// Output chunk channel: one field of the encoded stream per beat.
interface efbe_out_if;
  import efbe_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [CHUNK_W-1:0]      chunk;
  logic [CHUNK_BITS_W-1:0] chunk_bits;
  logic                    last_chunk;

  modport source (output valid, output chunk, output chunk_bits, output last_chunk, input ready);
  modport sink (input valid, input chunk, input chunk_bits, input last_chunk, output ready);
endinterface

[rtl/core/efbe_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module efbe_ram #(
  parameter int WIDTH     = 40,
  parameter int DEPTH     = 64,
  parameter int ADDR_BITS = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [ADDR_BITS-1:0] wr_addr,
  input  logic [WIDTH-1:0]     wr_data,
  input  logic                 rd_en,
  input  logic [ADDR_BITS-1:0] rd_addr,
  output logic [WIDTH-1:0]     rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/core/efbe_front.sv]
// Front end: accumulates prefix sums, captures hint sums and queues flushed blocks.
module efbe_front #(
  parameter int BLOCK_SIZE = 32,
  parameter int SUB_BLOCKS = 7,
  parameter int VALUE_BITS = 32,
  parameter int ADDR_BITS  = $clog2(2 * BLOCK_SIZE)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          valid,
  output logic                          ready,
  input  logic                          kind,
  input  logic [efbe_pkg::VALUE_W-1:0]  value,
  input  logic                          full,
  output logic                          wr_en,
  output logic [ADDR_BITS-1:0]          wr_addr,
  output logic [efbe_pkg::SUM_BITS-1:0] wr_data,
  output logic                          push,
  output efbe_pkg::job_t                push_job
);
  import efbe_pkg::*;

  localparam int STEP = (BLOCK_SIZE + SUB_BLOCKS - 1) / SUB_BLOCKS;

  logic [FILL_BITS-1:0]  fill;
  logic                  bank;
  logic [SUM_BITS-1:0]   last_sum;
  logic [SUM_BITS-1:0]   hint_cap [HINT_SLOTS];
  logic                  accept;
  logic                  do_add;
  logic                  do_flush;
  logic [SUM_BITS-1:0]   sum_new;
  logic [MAX_WIDTH:0]    ge;
  logic [MAX_WIDTH:0]    first;
  logic [WIDTH_BITS-1:0] width;

  assign ready    = !full;
  assign accept   = valid && ready;
  assign do_add   = accept && (kind == KIND_ADD) && (fill < FILL_BITS'(BLOCK_SIZE));
  assign do_flush = accept && (kind == KIND_FLUSH) && (fill != '0);
  assign sum_new  = last_sum + SUM_BITS'(value[VALUE_BITS-1:0]);

  assign wr_en   = do_add;
  assign wr_data = sum_new;
  assign wr_addr = bank ? ADDR_BITS'(fill) + ADDR_BITS'(BLOCK_SIZE) : ADDR_BITS'(fill);
  assign push    = do_flush;

  // The width is the smallest w for which the last sum lies below BLOCK_SIZE << w.
  always_comb begin
    for (int w = 0; w <= MAX_WIDTH; w++) begin
      ge[w] = THR_BITS'(last_sum) >= (THR_BITS'(BLOCK_SIZE) << w);
    end
    first[0] = !ge[0];
    for (int w = 1; w <= MAX_WIDTH; w++) begin
      first[w] = ge[w-1] && !ge[w];
    end
    width = '0;
    for (int w = 0; w <= MAX_WIDTH; w++) begin
      if (first[w]) begin
        width = width | WIDTH_BITS'(w);
      end
    end
  end

  always_comb begin
    push_job.bank  = bank;
    push_job.fill  = fill;
    push_job.last  = last_sum;
    push_job.width = width;
    for (int p = 0; p < HINT_SLOTS; p++) begin
      push_job.hint_sum[p] = (FILL_BITS'(hint_index(p + 1, STEP, BLOCK_SIZE)) < fill) ?
                             hint_cap[p] : last_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill     <= '0;
      bank     <= 1'b0;
      last_sum <= '0;
    end else if (do_add) begin
      fill     <= fill + FILL_BITS'(1);
      last_sum <= sum_new;
    end else if (do_flush) begin
      fill     <= '0;
      bank     <= !bank;
      last_sum <= '0;
    end
  end

  always_ff @(posedge clk) begin
    for (int p = 0; p < HINT_SLOTS; p++) begin
      if (do_add && (p < SUB_BLOCKS - 1) &&
          (fill == FILL_BITS'(hint_index(p + 1, STEP, BLOCK_SIZE)))) begin
        hint_cap[p] <= sum_new;
      end
    end
  end

endmodule

[rtl/core/efbe_queue.sv]
// Two-entry queue of flushed block descriptors between front and back end.
`include "elias_fano_block_encoder_core_macros.svh"

module efbe_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  efbe_pkg::job_t push_job,
  input  logic           pop,
  output efbe_pkg::job_t head_job,
  output logic           head_valid,
  output logic           full
);
  import efbe_pkg::*;

  logic [1:0] count;
  logic       wr_ptr;
  logic       rd_ptr;
  job_t       slots [2];

  assign head_job   = slots[rd_ptr];
  assign head_valid = count != 2'd0;
  assign full       = count == 2'd2;

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  `EFBE_ASSERT_SAME(a_no_push_when_full, push, !full, "block queued while both banks are held")
  `EFBE_ASSERT_SAME(a_no_pop_when_empty, pop, head_valid, "block retired from an empty queue")

endmodule

[rtl/core/efbe_back.sv]
// Back end: walks a queued block and emits width, hints, low fields and high words.
`include "elias_fano_block_encoder_core_macros.svh"

module efbe_back #(
  parameter int BLOCK_SIZE = 32,
  parameter int SUB_BLOCKS = 7,
  parameter int ADDR_BITS  = $clog2(2 * BLOCK_SIZE)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              head_valid,
  input  efbe_pkg::job_t                    head_job,
  output logic                              pop,
  output logic                              rd_en,
  output logic [ADDR_BITS-1:0]              rd_addr,
  input  logic [efbe_pkg::SUM_BITS-1:0]     rd_data,
  output logic                              valid,
  input  logic                              ready,
  output logic [efbe_pkg::CHUNK_W-1:0]      chunk,
  output logic [efbe_pkg::CHUNK_BITS_W-1:0] chunk_bits,
  output logic                              last_chunk
);
  import efbe_pkg::*;

  localparam int STEP       = (BLOCK_SIZE + SUB_BLOCKS - 1) / SUB_BLOCKS;
  localparam int IDX_BITS   = $clog2(BLOCK_SIZE);
  localparam int HIGH_WORDS = (2 * BLOCK_SIZE + 63) / 64;
  localparam int HIGH_BITS  = HIGH_WORDS * CHUNK_W;
  localparam int POS_BITS   = SUM_BITS + 1;

  back_state_t             state;
  back_state_t             state_next;
  logic [IDX_BITS-1:0]     idx;
  logic [IDX_BITS-1:0]     idx_next;
  logic [HIGH_BITS-1:0]    bitmap;
  logic [CHUNK_BITS_W-1:0] hi_left;

  logic                    can_take;
  logic                    low_go;
  logic                    last_idx;
  logic                    hi_final;
  logic [SUM_BITS-1:0]     sum_val;
  logic [SUM_BITS-1:0]     shifted;
  logic [POS_BITS-1:0]     pos;
  logic [HIGH_BITS-1:0]    set_bit;
  logic [CHUNK_W-1:0]      low_chunk;
  logic [CHUNK_W-1:0]      hint_word;
  logic [CHUNK_BITS_W-1:0] total_high;
  logic                    emit;
  logic [CHUNK_W-1:0]      emit_chunk;
  logic [CHUNK_BITS_W-1:0] emit_bits;
  logic                    emit_last;

  assign can_take = !valid || ready;
  assign low_go   = (head_job.width == '0) || can_take;
  assign last_idx = idx == IDX_BITS'(BLOCK_SIZE - 1);
  assign hi_final = hi_left <= CHUNK_BITS_W'(CHUNK_W);

  // Positions at or past the fill count hold the padded sum.
  assign sum_val    = (FILL_BITS'(idx) < head_job.fill) ? rd_data : head_job.last;
  assign shifted    = sum_val >> head_job.width;
  assign pos        = POS_BITS'(shifted) + POS_BITS'(idx);
  assign set_bit    = (pos < POS_BITS'(HIGH_BITS)) ? (HIGH_BITS'(1) << pos) : '0;
  assign low_chunk  = CHUNK_W'(sum_val & ~({SUM_BITS{1'b1}} << head_job.width));
  assign total_high = CHUNK_BITS_W'(head_job.last >> head_job.width) +
                      CHUNK_BITS_W'(BLOCK_SIZE);

  always_comb begin
    hint_word = '0;
    for (int p = 0; p < HINT_SLOTS; p++) begin
      if (p < SUB_BLOCKS - 1) begin
        hint_word[p*HINT_FIELD_BITS +: HINT_FIELD_BITS] =
          HINT_FIELD_BITS'(head_job.hint_sum[p] >> head_job.width) +
          HINT_FIELD_BITS'(hint_index(p + 1, STEP, BLOCK_SIZE));
      end
    end
  end

  assign idx_next = (state == BK_LOW) ? idx + IDX_BITS'(1) : '0;
  assign rd_addr  = head_job.bank ? ADDR_BITS'(idx_next) + ADDR_BITS'(BLOCK_SIZE)
                                  : ADDR_BITS'(idx_next);

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (head_valid && can_take) begin
          state_next = BK_HINT;
        end
      end
      BK_HINT: begin
        if (can_take) begin
          state_next = BK_LOW;
        end
      end
      BK_LOW: begin
        if (low_go && last_idx) begin
          state_next = BK_HIGH;
        end
      end
      BK_HIGH: begin
        if (can_take && hi_final) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    emit       = 1'b0;
    emit_chunk = '0;
    emit_bits  = '0;
    emit_last  = 1'b0;
    rd_en      = 1'b0;
    pop        = 1'b0;
    unique case (state)
      BK_IDLE: begin
        emit       = head_valid && can_take;
        emit_chunk = CHUNK_W'(head_job.width);
        emit_bits  = CHUNK_BITS_W'(WIDTH_FIELD_BITS);
      end
      BK_HINT: begin
        emit       = can_take;
        emit_chunk = hint_word;
        emit_bits  = CHUNK_BITS_W'(CHUNK_W);
        rd_en      = can_take;
      end
      BK_LOW: begin
        emit       = can_take && (head_job.width != '0);
        emit_chunk = low_chunk;
        emit_bits  = CHUNK_BITS_W'(head_job.width);
        rd_en      = low_go && !last_idx;
      end
      BK_HIGH: begin
        emit       = can_take;
        emit_chunk = bitmap[CHUNK_W-1:0];
        emit_bits  = hi_final ? hi_left : CHUNK_BITS_W'(CHUNK_W);
        emit_last  = hi_final;
        pop        = can_take && hi_final;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
      valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        valid <= 1'b1;
      end else if (ready) begin
        valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      chunk      <= emit_chunk;
      chunk_bits <= emit_bits;
      last_chunk <= emit_last;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == BK_HINT) && can_take) begin
      idx     <= '0;
      bitmap  <= '0;
      hi_left <= total_high;
    end else if ((state == BK_LOW) && low_go) begin
      idx    <= idx_next;
      bitmap <= bitmap | set_bit;
    end else if ((state == BK_HIGH) && can_take) begin
      bitmap  <= bitmap >> CHUNK_W;
      hi_left <= hi_left - CHUNK_BITS_W'(CHUNK_W);
    end
  end

  `EFBE_ASSERT_SAME(a_pop_on_final_word, pop, (state == BK_HIGH) && hi_final, "block retired early")
  `EFBE_ASSERT_SAME(a_high_not_empty, state == BK_HIGH, hi_left != '0, "empty high stream walked")
  `EFBE_ASSERT_NEXT(a_hint_starts_walk, (state == BK_HINT) && can_take, state == BK_LOW, "walk skipped")

endmodule

[rtl/core/elias_fano_block_encoder_core.sv]
// Top level of the block encoder: an add beat is taken every cycle while a bank is free.
// A flush descriptor is registered in the queue and each chunk in the output register. Chunks
// follow one per cycle while the output is ready: width, hints, BLOCK_SIZE low fields (silent
// cycles when the width is zero) and one high word per 64 high bits. Low fields are read through
// the single read port of the sum memory. Two flushed blocks queue in separate banks.
// Synchronous reset empties the block and the queue; the sum memory is not cleared.
module elias_fano_block_encoder_core #(
  parameter int BLOCK_SIZE = 32,
  parameter int SUB_BLOCKS = 7,
  parameter int VALUE_BITS = 32
) (
  input logic        clk,
  input logic        rst,
  efbe_in_if.sink    items,
  efbe_out_if.source chunks
);
  import efbe_pkg::*;

  localparam int ADDR_BITS = $clog2(2 * BLOCK_SIZE);

  logic                 full;
  logic                 wr_en;
  logic [ADDR_BITS-1:0] wr_addr;
  logic [SUM_BITS-1:0]  wr_data;
  logic                 push;
  job_t                 push_job;
  logic                 pop;
  job_t                 head_job;
  logic                 head_valid;
  logic                 rd_en;
  logic [ADDR_BITS-1:0] rd_addr;
  logic [SUM_BITS-1:0]  rd_data;

  efbe_front #(
    .BLOCK_SIZE (BLOCK_SIZE),
    .SUB_BLOCKS (SUB_BLOCKS),
    .VALUE_BITS (VALUE_BITS),
    .ADDR_BITS  (ADDR_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .valid    (items.valid),
    .ready    (items.ready),
    .kind     (items.kind),
    .value    (items.value),
    .full     (full),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .push     (push),
    .push_job (push_job)
  );

  efbe_ram #(
    .WIDTH     (SUM_BITS),
    .DEPTH     (2 * BLOCK_SIZE),
    .ADDR_BITS (ADDR_BITS)
  ) u_sums (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  efbe_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .pop        (pop),
    .head_job   (head_job),
    .head_valid (head_valid),
    .full       (full)
  );

  efbe_back #(
    .BLOCK_SIZE (BLOCK_SIZE),
    .SUB_BLOCKS (SUB_BLOCKS),
    .ADDR_BITS  (ADDR_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .valid      (chunks.valid),
    .ready      (chunks.ready),
    .chunk      (chunks.chunk),
    .chunk_bits (chunks.chunk_bits),
    .last_chunk (chunks.last_chunk)
  );

endmodule

[tb/tb_elias_fano_block_encoder_core.sv]
// Self-checking testbench for the Elias-Fano block encoder core.
`timescale 1ns / 100ps

module tb_elias_fano_block_encoder_core;
  import efbe_pkg::*;

  localparam int BLOCK_SIZE   = 32;
  localparam int SUB_BLOCKS   = 7;
  localparam int VALUE_BITS   = 32;
  localparam int HIGH_WORDS   = (2 * BLOCK_SIZE + 63) / 64;
  localparam int RANDOM_ITEMS = 60;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 60;
  localparam int TIMEOUT_NS   = 4_000_000;

  typedef struct packed {
    logic [CHUNK_W-1:0]      chunk;
    logic [CHUNK_BITS_W-1:0] bits;
    logic                    last;
  } chunk_beat_t;

  typedef struct {
    logic               kind;
    logic [VALUE_W-1:0] value;
    int                 reps;
    bit                 typed;
    logic [6:0]         width;
  } script_row_t;

  localparam int SCRIPT_ROWS = 18;

  logic clk;
  logic rst;

  efbe_in_if  items_if ();
  efbe_out_if chunks_if ();

  elias_fano_block_encoder_core #(
    .BLOCK_SIZE(BLOCK_SIZE),
    .SUB_BLOCKS(SUB_BLOCKS),
    .VALUE_BITS(VALUE_BITS)
  ) DUT (
    .clk    (clk),
    .rst    (rst),
    .items  (items_if),
    .chunks (chunks_if)
  );

  logic [SUM_BITS-1:0] block_sums [BLOCK_SIZE];
  int                  block_fill;
  chunk_beat_t         expected_chunks [$];
  int                  chunk_errors;
  int                  gap_pct;
  int                  stall_pct;
  logic                hold_req;

  script_row_t script [SCRIPT_ROWS] = '{
    '{KIND_FLUSH, 32'h0000_0000, 1,  1'b0, 7'd0},
    '{KIND_ADD,   32'h0000_0000, 1,  1'b0, 7'd0},
    '{KIND_FLUSH, 32'h0000_0000, 1,  1'b1, 7'd0},
    '{KIND_ADD,   32'h0000_0020, 1,  1'b0, 7'd0},
    '{KIND_FLUSH, 32'hFFFF_FFFF, 1,  1'b1, 7'd1},
    '{KIND_ADD,   32'hFFFF_FFFF, 1,  1'b0, 7'd0},
    '{KIND_FLUSH, 32'h0000_0000, 1,  1'b1, 7'd27},
    '{KIND_ADD,   32'hFFFF_FFFF, 33, 1'b0, 7'd0},
    '{KIND_FLUSH, 32'h0000_0000, 1,  1'b1, 7'd32},
    '{KIND_FLUSH, 32'h0000_0000, 1,  1'b0, 7'd0},
    '{KIND_ADD,   32'h5555_5555, 3,  1'b0, 7'd0},
    '{KIND_ADD,   32'hAAAA_AAAA, 2,  1'b0, 7'd0},
    '{KIND_ADD,   32'h0000_0000, 1,  1'b0, 7'd0},
    '{KIND_FLUSH, 32'h0000_0000, 1,  1'b0, 7'd0},
    '{KIND_ADD,   32'h0000_0003, 10, 1'b0, 7'd0},
    '{KIND_FLUSH, 32'h0000_0000, 1,  1'b0, 7'd0},
    '{KIND_ADD,   32'h8000_0000, 5,  1'b0, 7'd0},
    '{KIND_FLUSH, 32'h0000_0000, 1,  1'b0, 7'd0}
  };

  function automatic logic [63:0] low_bits(input logic [63:0] v, input int bits);
    if (bits >= 64) begin
      return v;
    end
    return v & ((64'd1 << bits) - 64'd1);
  endfunction

  function automatic int ceil_log2(input logic [63:0] x);
    int w;
    w = 0;
    while (w < 63 && (64'd1 << w) < x) begin
      w++;
    end
    return w;
  endfunction

  // Positions past the fill level hold the padded sum.
  function automatic logic [63:0] padded_sum(input int p);
    if (p >= block_fill) begin
      p = block_fill - 1;
    end
    return 64'(block_sums[p]);
  endfunction

  function automatic void predict_chunks(input logic kind, input logic [VALUE_W-1:0] value,
                                         ref chunk_beat_t beats [$]);
    logic [63:0] last_sum;
    logic [63:0] hints;
    logic [63:0] hint_val;
    logic [63:0] pos;
    logic [63:0] high_words [HIGH_WORDS];
    logic [63:0] prev;
    int          width;
    int          step;
    int          idx;
    int          total;
    int          done;
    int          len;
    beats.delete();
    if (kind == KIND_ADD) begin
      if (block_fill < BLOCK_SIZE) begin
        prev = (block_fill > 0) ? 64'(block_sums[block_fill - 1]) : 64'd0;
        block_sums[block_fill] = SUM_BITS'(prev + low_bits(64'(value), VALUE_BITS));
        block_fill++;
      end
      return;
    end
    if (block_fill == 0) begin
      return;
    end
    last_sum = 64'(block_sums[block_fill - 1]);
    width    = ceil_log2(64'd1 + last_sum / 64'(BLOCK_SIZE));
    hints    = 64'd0;
    step     = (BLOCK_SIZE + SUB_BLOCKS - 1) / SUB_BLOCKS;
    for (int p = 0; p + 1 < SUB_BLOCKS && p < HINT_SLOTS; p++) begin
      idx = (p + 1) * step - 1;
      if (idx > BLOCK_SIZE - 1) begin
        idx = BLOCK_SIZE - 1;
      end
      hint_val = (padded_sum(idx) >> width) + 64'(idx);
      hints |= low_bits(hint_val, HINT_FIELD_BITS) << (p * HINT_FIELD_BITS);
    end
    beats.insert(beats.size(), chunk_beat_t'{64'(width), 7'(WIDTH_FIELD_BITS), 1'b0});
    beats.insert(beats.size(), chunk_beat_t'{hints, 7'd64, 1'b0});
    if (width > 0) begin
      for (int p = 0; p < BLOCK_SIZE; p++) begin
        beats.insert(beats.size(),
                     chunk_beat_t'{low_bits(padded_sum(p), width), 7'(width), 1'b0});
      end
    end
    foreach (high_words[w]) begin
      high_words[w] = 64'd0;
    end
    total = 0;
    for (int p = 0; p < BLOCK_SIZE; p++) begin
      pos = (padded_sum(p) >> width) + 64'(p);
      if (pos < 64'(HIGH_WORDS * 64)) begin
        high_words[pos >> 6][pos[5:0]] = 1'b1;
      end
      if (pos + 64'd1 > 64'(total)) begin
        total = int'(pos + 64'd1);
      end
    end
    if (total > HIGH_WORDS * 64) begin
      total = HIGH_WORDS * 64;
    end
    done = 0;
    while (done < total) begin
      len = (total - done > 64) ? 64 : total - done;
      beats.insert(beats.size(),
                   chunk_beat_t'{low_bits(high_words[done >> 6], len), 7'(len),
                                 (done + len >= total) ? 1'b1 : 1'b0});
      done += len;
    end
    block_fill = 0;
  endfunction

  // Entered and left at a falling edge; the beat is held until it is taken.
  task automatic put_item(input logic kind, input logic [VALUE_W-1:0] value,
                          input bit typed, input logic [6:0] typed_width);
    chunk_beat_t beats [$];
    while ($urandom_range(0, 99) < gap_pct) begin
      items_if.valid <= 1'b0;
      items_if.kind  <= 1'($urandom_range(0, 1));
      items_if.value <= $urandom;
      @(negedge clk);
    end
    items_if.valid <= 1'b1;
    items_if.kind  <= kind;
    items_if.value <= value;
    do begin
      @(posedge clk);
    end while (!items_if.ready);
    predict_chunks(kind, value, beats);
    if (typed && beats.size() > 0) begin
      beats[0].chunk = 64'(typed_width);
    end
    foreach (beats[i]) begin
      expected_chunks.insert(expected_chunks.size(), beats[i]);
    end
    @(negedge clk);
  endtask

  function automatic logic [VALUE_W-1:0] random_value();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return $urandom >> $urandom_range(0, 31);
    endcase
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int hold_left;
    bit hold_taken;
    hold_left       = 0;
    hold_taken      = 1'b0;
    chunks_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        chunks_if.ready <= 1'b0;
      end else begin
        chunks_if.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    chunk_beat_t want;
    if (!rst && chunks_if.valid && chunks_if.ready) begin
      if (expected_chunks.size() == 0) begin
        chunk_errors++;
        if (chunk_errors <= 10) begin
          $display("Unexpected chunk beat: %h bits %0d last %0b", chunks_if.chunk,
                   chunks_if.chunk_bits, chunks_if.last_chunk);
        end
      end else begin
        want = expected_chunks.pop_front();
        if (chunks_if.chunk !== want.chunk || chunks_if.chunk_bits !== want.bits ||
            chunks_if.last_chunk !== want.last) begin
          chunk_errors++;
          if (chunk_errors <= 10) begin
            $display("Chunk mismatch: expected %h bits %0d last %0b, got %h bits %0d last %0b",
                     want.chunk, want.bits, want.last, chunks_if.chunk,
                     chunks_if.chunk_bits, chunks_if.last_chunk);
          end
        end
      end
    end
  end

  initial begin
    int sent;
    int phase;
    int run_len;
    rst            = 1'b1;
    items_if.valid = 1'b0;
    items_if.kind  = KIND_ADD;
    items_if.value = '0;
    block_fill     = 0;
    chunk_errors   = 0;
    gap_pct        = 0;
    stall_pct      = 0;
    hold_req       = 1'b0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    foreach (script[r]) begin
      for (int k = 0; k < script[r].reps; k++) begin
        put_item(script[r].kind, script[r].value, script[r].typed, script[r].width);
      end
    end

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      phase = sent * 4 / RANDOM_ITEMS;
      case (phase)
        0: begin
          gap_pct = 0;
          stall_pct <= 0;
          hold_req  <= 1'b1;
        end
        1: begin
          gap_pct = 83;
          stall_pct <= 0;
        end
        2: begin
          gap_pct = 0;
          stall_pct <= 83;
        end
        default: begin
          gap_pct = 35;
          stall_pct <= 35;
        end
      endcase
      run_len = ($urandom_range(0, 7) == 0) ? $urandom_range(BLOCK_SIZE - 2, BLOCK_SIZE + 2)
                                            : $urandom_range(1, 6);
      for (int k = 0; k < run_len; k++) begin
        put_item(KIND_ADD, random_value(), 1'b0, 7'd0);
        sent++;
      end
      put_item(KIND_FLUSH, $urandom, 1'b0, 7'd0);
      sent++;
      if ($urandom_range(0, 9) == 0) begin
        put_item(KIND_FLUSH, $urandom, 1'b0, 7'd0);
        sent++;
      end
    end
    items_if.valid <= 1'b0;
    stall_pct <= 0;

    while (expected_chunks.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (chunk_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
